// ----- design/mvab_pkg.sv -----
package mvab_pkg;

	localparam int MAX_VERTICES         = 1024;
	localparam int MAX_NEIGHBOURS       = 16;
	localparam int MAX_FACES_PER_VERTEX = 16;
	localparam int FACE_NUMBER_BITS     = 16;

	localparam int VW  = 10;
	localparam int NCW = $clog2(MAX_NEIGHBOURS + 1);
	localparam int FCW = $clog2(MAX_FACES_PER_VERTEX + 1);
	localparam int NIW = $clog2(MAX_NEIGHBOURS);
	localparam int FIW = $clog2(MAX_FACES_PER_VERTEX);
	localparam int NAW = VW + NIW;
	localparam int FAW = VW + FIW;
	localparam int FNW = FACE_NUMBER_BITS + 1;

	localparam logic [1:0] KIND_ACK   = 2'd0;
	localparam logic [1:0] KIND_NEIGH = 2'd1;
	localparam logic [1:0] KIND_FACE  = 2'd2;
	localparam logic [1:0] KIND_EMPTY = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DROP    = 2'd1;
	localparam logic [1:0] ST_EXHAUST = 2'd2;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// datapath commands from controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,     // capture input item
		OP_CNT_RD,   // read counts of selected owner
		OP_FACE_APP, // append face to owner
		OP_NB_RD,    // read neighbour entry at scan index
		OP_NB_CMP,   // compare read entry with partner
		OP_NB_APP,   // append partner to owner
		OP_EMIT_ACK,
		OP_EMIT_NB,
		OP_EMIT_FC,
		OP_EMIT_EMPTY,
		OP_CLEAR     // clear one count entry after reset
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] owner;   // corner index
		logic [1:0] partner; // corner index
		logic [4:0] idx;     // list scan / read index
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic           cmd;
		logic           exhausted;
		logic           owner_ok;
		logic [NCW-1:0] ncount;
		logic [FCW-1:0] fcount;
		logic           match;
		logic           clear_done;
	} sts_t;

endpackage

// ----- design/mvab_ram.sv -----
module mvab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- design/mvab_datapath.sv -----
module mvab_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mvab_pkg::cmd_t      cmd,
	input  logic                command,
	input  logic [9:0]          vertex_a,
	input  logic [9:0]          vertex_b,
	input  logic [9:0]          vertex_c,
	output mvab_pkg::sts_t      sts,
	output logic                strobe,
	output logic [1:0]          kind,
	output logic [15:0]         value,
	output logic [1:0]          status,
	output logic                last
);
	localparam int VW  = mvab_pkg::VW;
	localparam int NCW = mvab_pkg::NCW;
	localparam int FCW = mvab_pkg::FCW;
	localparam int NIW = mvab_pkg::NIW;
	localparam int FIW = mvab_pkg::FIW;
	localparam int FNW = mvab_pkg::FNW;

	logic          cmd_q;
	logic [VW-1:0] v_q [3];
	logic [FNW-1:0] face_next_q;
	logic          drop_q;
	logic [VW-1:0] owner, partner;
	logic          owner_ok;

	logic [NCW-1:0] ncnt_rd, ncnt_q;
	logic [FCW-1:0] fcnt_rd, fcnt_q;
	logic [VW-1:0]  nent_rd;
	logic [FNW-2:0] fent_rd;
	logic           match_q;

	assign owner    = v_q[cmd.owner];
	assign partner  = v_q[cmd.partner];
	assign owner_ok = ({{(32-VW){1'b0}}, owner} < mvab_pkg::MAX_VERTICES);

	logic nc_we, fc_we, ne_we, fe_we;
	assign nc_we = (cmd.op == mvab_pkg::OP_NB_APP) && owner_ok &&
		(ncnt_q < NCW'(mvab_pkg::MAX_NEIGHBOURS)) && !match_q;
	assign ne_we = nc_we;
	assign fc_we = (cmd.op == mvab_pkg::OP_FACE_APP) && owner_ok &&
		(fcnt_q < FCW'(mvab_pkg::MAX_FACES_PER_VERTEX));
	assign fe_we = fc_we;

	// count memories: zeroed by a clearing pass over every vertex after reset
	logic [VW-1:0] clr_q;
	logic          clr_en;
	assign clr_en = (cmd.op == mvab_pkg::OP_CLEAR);

	mvab_ram #(.WIDTH(NCW), .DEPTH(mvab_pkg::MAX_VERTICES)) u_ncnt (
		.clk(clk), .we(nc_we || clr_en), .waddr(clr_en ? clr_q : owner),
		.wdata(clr_en ? NCW'(0) : ncnt_q + NCW'(1)),
		.raddr(owner), .rdata(ncnt_rd));
	mvab_ram #(.WIDTH(FCW), .DEPTH(mvab_pkg::MAX_VERTICES)) u_fcnt (
		.clk(clk), .we(fc_we || clr_en), .waddr(clr_en ? clr_q : owner),
		.wdata(clr_en ? FCW'(0) : fcnt_q + FCW'(1)),
		.raddr(owner), .rdata(fcnt_rd));

	// list entry memories
	mvab_ram #(.WIDTH(VW), .DEPTH(mvab_pkg::MAX_VERTICES * mvab_pkg::MAX_NEIGHBOURS)) u_nent (
		.clk(clk), .we(ne_we), .waddr({owner, ncnt_q[NIW-1:0]}), .wdata(partner),
		.raddr({owner, cmd.idx[NIW-1:0]}), .rdata(nent_rd));
	mvab_ram #(.WIDTH(FNW-1),
		.DEPTH(mvab_pkg::MAX_VERTICES * mvab_pkg::MAX_FACES_PER_VERTEX)) u_fent (
		.clk(clk), .we(fe_we), .waddr({owner, fcnt_q[FIW-1:0]}),
		.wdata(face_next_q[FNW-2:0]),
		.raddr({owner, cmd.idx[FIW-1:0]}), .rdata(fent_rd));

	// clear address, face number counter, drop flag and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			face_next_q <= '0;
			strobe      <= 1'b0;
			drop_q      <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (cmd.op)
				mvab_pkg::OP_CLEAR: begin
					clr_q <= clr_q + VW'(1);
				end
				mvab_pkg::OP_LOAD: begin
					drop_q <= 1'b0;
				end
				mvab_pkg::OP_FACE_APP: begin
					if (owner_ok && !fc_we) drop_q <= 1'b1;
				end
				mvab_pkg::OP_NB_APP: begin
					if (owner_ok && !match_q &&
						!(ncnt_q < NCW'(mvab_pkg::MAX_NEIGHBOURS))) drop_q <= 1'b1;
				end
				mvab_pkg::OP_EMIT_ACK: begin
					strobe <= 1'b1;
					// face number moves on once it has been given out
					if (!face_next_q[FNW-1]) face_next_q <= face_next_q + FNW'(1);
				end
				mvab_pkg::OP_EMIT_NB, mvab_pkg::OP_EMIT_FC,
				mvab_pkg::OP_EMIT_EMPTY: begin
					strobe <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == mvab_pkg::OP_LOAD) begin
			cmd_q  <= command;
			v_q[0] <= vertex_a;
			v_q[1] <= vertex_b;
			v_q[2] <= vertex_c;
		end
		if (cmd.op == mvab_pkg::OP_CNT_RD) begin
			ncnt_q <= ncnt_rd;
			fcnt_q <= fcnt_rd;
		end
		if (cmd.op == mvab_pkg::OP_NB_APP && nc_we) ncnt_q <= ncnt_q + NCW'(1);
		if (cmd.op == mvab_pkg::OP_FACE_APP && fc_we) fcnt_q <= fcnt_q + FCW'(1);
		if (cmd.op == mvab_pkg::OP_LOAD || cmd.op == mvab_pkg::OP_CNT_RD) match_q <= 1'b0;
		if (cmd.op == mvab_pkg::OP_NB_CMP && nent_rd == partner) match_q <= 1'b1;
		case (cmd.op)
			mvab_pkg::OP_EMIT_ACK: begin
				kind   <= mvab_pkg::KIND_ACK;
				last   <= 1'b1;
				if (face_next_q[FNW-1]) begin
					value  <= '0;
					status <= mvab_pkg::ST_EXHAUST;
				end else begin
					value  <= 16'(face_next_q[FNW-2:0]);
					status <= drop_q ? mvab_pkg::ST_DROP : mvab_pkg::ST_OK;
				end
			end
			mvab_pkg::OP_EMIT_NB: begin
				kind <= mvab_pkg::KIND_NEIGH; value <= 16'(nent_rd);
				status <= mvab_pkg::ST_OK; last <= cmd.last;
			end
			mvab_pkg::OP_EMIT_FC: begin
				kind <= mvab_pkg::KIND_FACE; value <= 16'(fent_rd);
				status <= mvab_pkg::ST_OK; last <= cmd.last;
			end
			mvab_pkg::OP_EMIT_EMPTY: begin
				kind <= mvab_pkg::KIND_EMPTY; value <= '0;
				status <= mvab_pkg::ST_OK; last <= 1'b1;
			end
			default: ;
		endcase
	end

	assign sts.cmd        = cmd_q;
	assign sts.exhausted  = face_next_q[FNW-1];
	assign sts.owner_ok   = owner_ok;
	assign sts.ncount     = ncnt_rd;
	assign sts.fcount     = fcnt_rd;
	assign sts.match      = match_q;
	assign sts.clear_done = (clr_q == VW'(mvab_pkg::MAX_VERTICES - 1));
endmodule

// ----- design/mvab_ctrl.sv -----
module mvab_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  mvab_pkg::sts_t      sts,
	output mvab_pkg::cmd_t      cmd
);
	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DECIDE, S_FC_ADDR, S_FC_CNT, S_FC_APP,
		S_NB_ADDR, S_NB_CNT, S_NB_RD, S_NB_WAIT, S_NB_CMP, S_NB_APP,
		S_ACK, S_RD_ADDR, S_RD_CNT, S_RD_WAIT, S_RD_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] corner_q;   // face owner
	logic [2:0] pair_q;     // neighbour pair number
	logic [4:0] idx_q;
	logic [5:0] nn_q, nf_q;
	logic [5:0] k_q;
	logic [1:0] own_c, par_c;

	// owner/partner for each of the six inserts
	always_comb begin
		case (pair_q)
			3'd0: begin own_c = 2'd0; par_c = 2'd1; end
			3'd1: begin own_c = 2'd0; par_c = 2'd2; end
			3'd2: begin own_c = 2'd1; par_c = 2'd0; end
			3'd3: begin own_c = 2'd1; par_c = 2'd2; end
			3'd4: begin own_c = 2'd2; par_c = 2'd0; end
			default: begin own_c = 2'd2; par_c = 2'd1; end
		endcase
	end

	logic [5:0] total;
	assign total = nn_q + nf_q;

	// command decode
	always_comb begin
		cmd = '{op: mvab_pkg::OP_NONE, owner: 2'd0, partner: 2'd0, idx: idx_q, last: 1'b0};
		case (state_q)
			S_CLEAR:   cmd.op = mvab_pkg::OP_CLEAR;
			S_IDLE:    cmd.op = start ? mvab_pkg::OP_LOAD : mvab_pkg::OP_NONE;
			S_FC_ADDR: cmd.owner = corner_q;
			S_FC_CNT:  begin cmd.owner = corner_q; cmd.op = mvab_pkg::OP_CNT_RD; end
			S_FC_APP:  begin cmd.owner = corner_q; cmd.op = mvab_pkg::OP_FACE_APP; end
			S_NB_ADDR: begin cmd.owner = own_c; cmd.partner = par_c; end
			S_NB_CNT:  begin cmd.owner = own_c; cmd.partner = par_c; cmd.op = mvab_pkg::OP_CNT_RD; end
			S_NB_RD, S_NB_WAIT: begin cmd.owner = own_c; cmd.partner = par_c; end
			S_NB_CMP:  begin cmd.owner = own_c; cmd.partner = par_c; cmd.op = mvab_pkg::OP_NB_CMP; end
			S_NB_APP:  begin cmd.owner = own_c; cmd.partner = par_c; cmd.op = mvab_pkg::OP_NB_APP; end
			S_ACK:     cmd.op = mvab_pkg::OP_EMIT_ACK;
			S_RD_CNT:  cmd.op = mvab_pkg::OP_CNT_RD;
			S_RD_WAIT: if (total == 6'd0) cmd.op = mvab_pkg::OP_EMIT_EMPTY;
			S_RD_EMIT: begin
				cmd.op   = (k_q < nn_q) ? mvab_pkg::OP_EMIT_NB : mvab_pkg::OP_EMIT_FC;
				cmd.last = (k_q + 6'd1 == total) || (k_q == 6'd31);
			end
			default: ;
		endcase
		if (state_q == S_RD_WAIT || state_q == S_RD_EMIT) begin
			cmd.idx = (k_q + 6'd1 < nn_q || (state_q == S_RD_WAIT && nn_q != 0)) ?
				5'(state_q == S_RD_WAIT ? 6'd0 : k_q + 6'd1) :
				5'((state_q == S_RD_WAIT ? 6'd0 : k_q + 6'd1) - nn_q);
		end
	end

	// sequencer: clear pass, face appends, per entry read scan for duplicates then append, read-out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			busy     <= 1'b1;
			corner_q <= '0;
			pair_q   <= '0;
			idx_q    <= '0;
			nn_q     <= '0;
			nf_q     <= '0;
			k_q      <= '0;
		end else begin
			case (state_q)
				S_CLEAR: if (sts.clear_done) begin
					busy <= 1'b0; state_q <= S_IDLE;
				end
				S_IDLE: if (start) begin
					busy <= 1'b1; state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					corner_q <= '0; pair_q <= '0; idx_q <= '0; k_q <= '0;
					if (sts.cmd == mvab_pkg::CMD_READ) state_q <= S_RD_ADDR;
					else if (sts.exhausted) state_q <= S_ACK;
					else state_q <= S_FC_ADDR;
				end
				S_FC_ADDR: state_q <= S_FC_CNT;
				S_FC_CNT:  state_q <= S_FC_APP;
				S_FC_APP: begin
					if (corner_q == 2'd2) state_q <= S_NB_ADDR;
					else begin corner_q <= corner_q + 2'd1; state_q <= S_FC_ADDR; end
				end
				S_NB_ADDR: state_q <= S_NB_CNT;
				S_NB_CNT: begin
					idx_q   <= '0;
					nn_q    <= 6'(sts.ncount);
					state_q <= (sts.ncount == '0 || !sts.owner_ok) ? S_NB_APP : S_NB_RD;
				end
				S_NB_RD:   state_q <= S_NB_WAIT;
				S_NB_WAIT: state_q <= S_NB_CMP;
				S_NB_CMP: begin
					if (6'(idx_q) + 6'd1 >= nn_q) state_q <= S_NB_APP;
					else begin idx_q <= idx_q + 5'd1; state_q <= S_NB_RD; end
				end
				S_NB_APP: begin
					if (pair_q == 3'd5) state_q <= S_ACK;
					else begin pair_q <= pair_q + 3'd1; state_q <= S_NB_ADDR; end
				end
				S_ACK: begin
					busy <= 1'b0; state_q <= S_IDLE;
				end
				S_RD_ADDR: state_q <= S_RD_CNT;
				S_RD_CNT: begin
					nn_q <= sts.owner_ok ? 6'(sts.ncount) : 6'd0;
					nf_q <= sts.owner_ok ? 6'(sts.fcount) : 6'd0;
					state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					if (total == 6'd0) begin
						busy <= 1'b0; state_q <= S_IDLE;
					end else state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					k_q <= k_q + 6'd1;
					if (cmd.last) begin busy <= 1'b0; state_q <= S_IDLE; end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- design/mesh_vertex_adjacency_builder.sv -----
// add item: decide, 3 face appends, 6 inserts each scanning the owner's list for duplicates, ack;
//   only the decide and the ack when face numbers are exhausted
// read item: address, count read and wait steps, then one result per cycle, up to 32 results
// one item at a time; busy high from acceptance to the last result; receiver cannot stall
// asynchronous reset clears face number and control, then a pass over every vertex clears
//   the counts with busy held high; list entry memories are not cleared
module mesh_vertex_adjacency_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [9:0]  vertex_a,
	input  logic [9:0]  vertex_b,
	input  logic [9:0]  vertex_c,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [15:0] value,
	output logic [1:0]  status,
	output logic        last
);
	mvab_pkg::cmd_t cmd;
	mvab_pkg::sts_t sts;

	// controller
	mvab_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd));

	// datapath
	mvab_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .command(command),
		.vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
		.sts(sts), .strobe(strobe), .kind(kind), .value(value),
		.status(status), .last(last));

	// no result while idle with nothing pending
	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !strobe) else $error("result while idle");

	// a last result ends the item
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy) else $error("busy after last result");
endmodule
